>>> rtl/bra_pkg.sv
package bra_pkg;

  localparam int WORD_BITS = 64;
  localparam int OFF_W     = 6;
  localparam int FUNC_W    = 3;
  localparam int INDEX_W   = 10;
  localparam int LEN_W     = 11;
  localparam int BYTES_W   = 8;
  localparam int LU_W      = 7;
  localparam int RUN_W     = 12;

  localparam logic [BYTES_W-1:0] BYTES_RESET = 8'd128;

  localparam logic [FUNC_W-1:0] OP_SCAN  = 3'd0;
  localparam logic [FUNC_W-1:0] OP_SET   = 3'd1;
  localparam logic [FUNC_W-1:0] OP_CLEAR = 3'd2;
  localparam logic [FUNC_W-1:0] OP_TEST  = 3'd3;
  localparam logic [FUNC_W-1:0] OP_WIPE  = 3'd4;

  typedef struct packed {
    logic capture;
    logic clr_wr;
    logic issue;
    logic addr_idx;
    logic wipe_wb;
    logic bit_wr;
    logic set_val;
    logic scan_take;
    logic bit_take;
    logic load;
    logic res_found;
    logic res_start;
    logic res_bit;
  } bra_cmd_t;

  typedef struct packed {
    logic need_zero;
    logic limit_zero;
    logic idx_ok;
    logic clr_last;
    logic issue_last;
    logic b_vld;
    logic hit;
    logic b_last;
    logic out_free;
  } bra_status_t;

endpackage

>>> rtl/bra_if.sv
interface bra_req_if;
  import bra_pkg::*;
  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [INDEX_W-1:0] bit_addr;
  logic [LEN_W-1:0]   run_length;
  modport source (output valid, output func, output bit_addr, output run_length, input ready);
  modport sink (input valid, input func, input bit_addr, input run_length, output ready);
endinterface

interface bra_rsp_if;
  import bra_pkg::*;
  logic               valid;
  logic               ready;
  logic               found;
  logic [INDEX_W-1:0] start_index;
  logic               bit_value;
  modport source (output valid, output found, output start_index, output bit_value, input ready);
  modport sink (input valid, input found, input start_index, input bit_value, output ready);
endinterface

interface bra_cfg_if;
  import bra_pkg::*;
  logic               valid;
  logic               ready;
  logic [BYTES_W-1:0] map_bytes_in_use;
  modport source (output valid, output map_bytes_in_use, input ready);
  modport sink (input valid, input map_bytes_in_use, output ready);
endinterface

>>> rtl/bra_ctrl.sv
module bra_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  input  logic [bra_pkg::FUNC_W-1:0] req_func,
  output logic                       req_ready,
  input  bra_pkg::bra_status_t       st,
  output bra_pkg::bra_cmd_t          cmd
);
  import bra_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_BIT_WR,
    S_WIPE,
    S_WIPE_END,
    S_DONE
  } state_t;

  state_t            state;
  logic [FUNC_W-1:0] op;
  logic              issued_all;
  logic              res_found;
  logic              res_start;
  logic              res_bit;

  always_comb begin
    cmd           = '0;
    req_ready     = 1'b0;
    cmd.res_found = res_found;
    cmd.res_start = res_start;
    cmd.res_bit   = res_bit;
    case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
      end
      S_IDLE: begin
        req_ready   = 1'b1;
        cmd.capture = req_valid;
      end
      S_DISPATCH: begin
        if ((op == OP_SET || op == OP_CLEAR || op == OP_TEST) && st.idx_ok) begin
          cmd.issue    = 1'b1;
          cmd.addr_idx = 1'b1;
        end
      end
      S_SCAN: begin
        cmd.issue     = !issued_all;
        cmd.scan_take = st.b_vld && st.hit;
      end
      S_BIT_WR: begin
        cmd.bit_take = (op == OP_TEST);
        cmd.bit_wr   = (op == OP_SET) || (op == OP_CLEAR);
        cmd.set_val  = (op == OP_SET);
      end
      S_WIPE: begin
        cmd.issue   = 1'b1;
        cmd.wipe_wb = 1'b1;
      end
      S_WIPE_END: begin
        cmd.wipe_wb = 1'b1;
      end
      S_DONE: begin
        cmd.load = st.out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      op         <= OP_SCAN;
      issued_all <= 1'b0;
      res_found  <= 1'b0;
      res_start  <= 1'b0;
      res_bit    <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          if (st.clr_last) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            op         <= req_func;
            issued_all <= 1'b0;
            state      <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          res_start <= 1'b0;
          case (op)
            OP_SCAN: begin
              res_bit <= 1'b0;
              if (st.need_zero || st.limit_zero) begin
                res_found <= 1'b0;
                state     <= S_DONE;
              end else begin
                res_found <= 1'b1;
                state     <= S_SCAN;
              end
            end
            OP_SET, OP_CLEAR, OP_TEST: begin
              if (!st.idx_ok) begin
                res_found <= 1'b0;
                res_bit   <= 1'b0;
                state     <= S_DONE;
              end else begin
                res_found <= 1'b1;
                res_bit   <= (op == OP_TEST);
                state     <= S_BIT_WR;
              end
            end
            OP_WIPE: begin
              res_found <= 1'b1;
              res_bit   <= 1'b0;
              if (st.limit_zero) begin
                state <= S_DONE;
              end else begin
                state <= S_WIPE;
              end
            end
            default: begin
              res_found <= 1'b0;
              res_bit   <= 1'b0;
              state     <= S_DONE;
            end
          endcase
        end
        S_SCAN: begin
          if (!issued_all && st.issue_last) begin
            issued_all <= 1'b1;
          end
          if (st.b_vld && st.hit) begin
            res_start <= 1'b1;
            state     <= S_DONE;
          end else if (st.b_vld && st.b_last) begin
            res_found <= 1'b0;
            state     <= S_DONE;
          end
        end
        S_BIT_WR: begin
          state <= S_DONE;
        end
        S_WIPE: begin
          if (st.issue_last) begin
            state <= S_WIPE_END;
          end
        end
        S_WIPE_END: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (st.out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/bra_datapath.sv
module bra_datapath #(
  parameter int MAP_BITS = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [bra_pkg::INDEX_W-1:0] bit_addr,
  input  logic [bra_pkg::LEN_W-1:0]   run_length,
  input  logic                        cfg_we,
  input  logic [bra_pkg::BYTES_W-1:0] cfg_data,
  output logic                        rsp_valid,
  input  logic                        rsp_ready,
  output logic                        found,
  output logic [bra_pkg::INDEX_W-1:0] start_index,
  output logic                        bit_value,
  input  bra_pkg::bra_cmd_t           cmd,
  output bra_pkg::bra_status_t        st
);
  import bra_pkg::*;

  localparam int DEPTH = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW    = $clog2(MAP_BITS + 1);
  localparam int PW    = (LW > LEN_W) ? LW : LEN_W;
  localparam int SW    = ((AW + OFF_W > LEN_W) ? AW + OFF_W : LEN_W) + 1;

  logic [BYTES_W-1:0]   map_bytes;
  logic [WORD_BITS-1:0] mem [0:DEPTH-1];
  logic [AW-1:0]        cnt;
  logic [INDEX_W-1:0]   index_q;
  logic [LEN_W-1:0]     need_q;
  logic [WORD_BITS-1:0] rd_data;
  logic [AW-1:0]        rd_row;
  logic                 rd_vld;
  logic [LU_W-1:0]      lu [0:WORD_BITS-1];
  logic [AW-1:0]        b_row;
  logic                 b_vld;
  logic [LEN_W-1:0]     carry;
  logic [INDEX_W-1:0]   r_start;
  logic                 r_bit;

  logic [PW-1:0]        limit;
  logic [PW-1:0]        lim_row;
  logic [AW-1:0]        last_row;
  logic [AW-1:0]        idx_row;
  logic [AW-1:0]        rd_addr;
  logic [WORD_BITS-1:0] beyond;
  logic [WORD_BITS-1:0] masked;
  logic [WORD_BITS-1:0] bit_word;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [WORD_BITS-1:0] wr_data;
  logic [LU_W-1:0]      pm [0:OFF_W][0:WORD_BITS-1];
  logic [RUN_W-1:0]     run [0:WORD_BITS-1];
  logic [WORD_BITS-1:0] hit;
  logic [OFF_W-1:0]     sel;
  logic [LEN_W-1:0]     carry_next;
  logic [SW-1:0]        start_w;

  assign limit    = (PW'({map_bytes, 3'b000}) > PW'(MAP_BITS)) ? PW'(MAP_BITS)
                                                               : PW'({map_bytes, 3'b000});
  assign lim_row  = limit >> OFF_W;
  assign last_row = AW'((limit - PW'(1)) >> OFF_W);
  assign idx_row  = AW'(PW'(index_q) >> OFF_W);
  assign rd_addr  = cmd.addr_idx ? idx_row : cnt;

  // Bits at or above the active limit count as used and survive a wipe.
  always_comb begin
    if (PW'(rd_row) > lim_row) begin
      beyond = '1;
    end else if (PW'(rd_row) == lim_row) begin
      beyond = ~((WORD_BITS'(1) << limit[OFF_W-1:0]) - WORD_BITS'(1));
    end else begin
      beyond = '0;
    end
  end

  assign masked = rd_data | beyond;

  always_comb begin
    bit_word                         = rd_data;
    bit_word[index_q[OFF_W-1:0]]     = cmd.set_val;
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cnt;
    wr_data = '0;
    if (cmd.clr_wr) begin
      wr_en = 1'b1;
    end else if (cmd.wipe_wb && rd_vld) begin
      wr_en   = 1'b1;
      wr_addr = rd_row;
      wr_data = rd_data & beyond;
    end else if (cmd.bit_wr) begin
      wr_en   = 1'b1;
      wr_addr = idx_row;
      wr_data = bit_word;
    end
  end

  // Prefix maximum gives, for each bit, one past the last used bit at or below it.
  always_comb begin
    for (int j = 0; j < WORD_BITS; j++) begin
      pm[0][j] = masked[j] ? LU_W'(j + 1) : '0;
    end
    for (int l = 0; l < OFF_W; l++) begin
      for (int j = 0; j < WORD_BITS; j++) begin
        if (j >= (1 << l) && pm[l][j - (1 << l)] > pm[l][j]) begin
          pm[l+1][j] = pm[l][j - (1 << l)];
        end else begin
          pm[l+1][j] = pm[l][j];
        end
      end
    end
  end

  always_comb begin
    for (int j = 0; j < WORD_BITS; j++) begin
      run[j] = (lu[j] == '0) ? RUN_W'(carry) + RUN_W'(j + 1)
                             : RUN_W'(j + 1) - RUN_W'(lu[j]);
      hit[j] = run[j] >= RUN_W'(need_q);
    end
    sel = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (hit[j]) begin
        sel = OFF_W'(j);
      end
    end
    carry_next = (lu[WORD_BITS-1] == '0)
                 ? LEN_W'(RUN_W'(carry) + RUN_W'(WORD_BITS))
                 : LEN_W'(RUN_W'(WORD_BITS) - RUN_W'(lu[WORD_BITS-1]));
    start_w    = SW'({b_row, sel}) + SW'(1) - SW'(need_q);
  end

  always_comb begin
    st.need_zero  = (need_q == '0);
    st.limit_zero = (map_bytes == '0);
    st.idx_ok     = PW'(index_q) < PW'(MAP_BITS);
    st.clr_last   = (cnt == AW'(DEPTH - 1));
    st.issue_last = (cnt == last_row);
    st.b_vld      = b_vld;
    st.hit        = |hit;
    st.b_last     = (b_row == last_row);
    st.out_free   = !rsp_valid || rsp_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      map_bytes <= BYTES_RESET;
      cnt       <= '0;
      rd_vld    <= 1'b0;
      b_vld     <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        map_bytes <= cfg_data;
      end
      if (cmd.capture) begin
        cnt    <= '0;
        rd_vld <= 1'b0;
        b_vld  <= 1'b0;
      end else begin
        if ((cmd.issue && !cmd.addr_idx) || cmd.clr_wr) begin
          cnt <= cnt + AW'(1);
        end
        rd_vld <= cmd.issue;
        b_vld  <= rd_vld;
      end
      if (cmd.load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      index_q <= bit_addr;
      need_q  <= run_length;
      carry   <= '0;
    end else if (b_vld) begin
      carry <= carry_next;
    end
    if (cmd.issue) begin
      rd_data <= mem[rd_addr];
      rd_row  <= rd_addr;
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_vld) begin
      lu    <= pm[OFF_W];
      b_row <= rd_row;
    end
    if (cmd.scan_take) begin
      r_start <= start_w[INDEX_W-1:0];
    end
    if (cmd.bit_take) begin
      r_bit <= rd_data[index_q[OFF_W-1:0]];
    end
    if (cmd.load) begin
      found       <= cmd.res_found;
      start_index <= cmd.res_start ? r_start : '0;
      bit_value   <= cmd.res_bit ? r_bit : 1'b0;
    end
  end

endmodule

>>> rtl/bitmap_run_allocator.sv
// First-fit allocator over a usage bitmap, one bit per unit, 1 meaning used.
// Requests arrive on req (func, bit_addr, run_length) and each produces one
// beat on rsp (found, start_index, bit_value). cfg writes the number of map
// bytes in use; it is always ready. The user must see that it is written only
// while the block is idle; the block itself does not enforce this. The map is
// held in a memory of 64-bit rows, one row read per cycle. One request is
// handled at a time. A scan reads one row per cycle and stops early when a
// run is found. Set, clear and test read the addressed row once, and set and
// clear write it back. A wipe reads and writes back every active row.
// Zero-length scans, scans and wipes of an empty map, and rejected requests
// give their result without reading the map.
// After reset the block clears all ceil(MAP_BITS / 64) rows (16 by default),
// one row per cycle; req is not ready meanwhile.
// Results sit in an output register. While the receiver stalls, the next
// request is still accepted and processed, and its result waits until the
// pending beat is taken.
module bitmap_run_allocator #(
  parameter int MAP_BITS = 1024
) (
  input logic     clk,
  input logic     rst,
  bra_req_if.sink req,
  bra_rsp_if.source rsp,
  bra_cfg_if.sink cfg
);
  import bra_pkg::*;

  bra_cmd_t    cmd;
  bra_status_t st;

  assign cfg.ready = 1'b1;

  bra_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_func  (req.func),
    .req_ready (req.ready),
    .st        (st),
    .cmd       (cmd)
  );

  bra_datapath #(
    .MAP_BITS (MAP_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .bit_addr    (req.bit_addr),
    .run_length  (req.run_length),
    .cfg_we      (cfg.valid && cfg.ready),
    .cfg_data    (cfg.map_bytes_in_use),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .found       (rsp.found),
    .start_index (rsp.start_index),
    .bit_value   (rsp.bit_value),
    .cmd         (cmd),
    .st          (st)
  );

endmodule

>>> rtl/bra_checker.sv
module bra_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_ready,
  input logic                        rsp_valid,
  input logic                        rsp_ready,
  input logic                        found,
  input logic [bra_pkg::INDEX_W-1:0] start_index,
  input logic                        bit_value
);
  import bra_pkg::*;

  // The map is cleared after reset before any request is taken.
  a_busy_after_reset: assert property (@(posedge clk) rst |=> !req_ready)
    else $error("request accepted during the clearing pass");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(found) && $stable(start_index)
                                && $stable(bit_value))
    else $error("stalled response beat changed");

  a_miss_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !found |-> start_index == '0 && !bit_value)
    else $error("failed request carries a start index or bit value");

  a_start_or_bit: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && start_index != '0 |-> !bit_value)
    else $error("response carries both a run start and a bit value");

endmodule

bind bitmap_run_allocator bra_checker u_bra_checker (
  .clk         (clk),
  .rst         (rst),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .found       (rsp.found),
  .start_index (rsp.start_index),
  .bit_value   (rsp.bit_value)
);

>>> verif/bitmap_run_allocator_test.sv
module bitmap_run_allocator_test;
  import bra_pkg::*;

  localparam int MAP_BITS = 1024;
  localparam int ITEMS = 1450;
  localparam int CALM_ITEMS = 200;
  localparam int CYCLE_LIMIT = 500000;

  localparam logic [FUNC_W-1:0] OP_RSVD_A = 3'd5;
  localparam logic [FUNC_W-1:0] OP_RSVD_B = 3'd6;
  localparam logic [FUNC_W-1:0] OP_RSVD_C = 3'd7;

  typedef struct packed {
    logic               found;
    logic [INDEX_W-1:0] start;
    logic               bit_value;
  } alloc_result_t;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [INDEX_W-1:0] idx;
    logic [LEN_W-1:0]   len;
    logic               fixed;
    logic               w_found;
    logic [INDEX_W-1:0] w_start;
    logic               w_bit;
  } probe_t;

  logic clk;
  logic rst;

  bra_req_if req();
  bra_rsp_if rsp();
  bra_cfg_if cfg();

  bitmap_run_allocator #(.MAP_BITS(MAP_BITS)) dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp),
    .cfg(cfg)
  );

  logic usage [MAP_BITS];
  logic [BYTES_W-1:0] map_bytes;
  alloc_result_t awaited [$];
  bit calm;
  int errors;
  int n_items;
  int n_scans;
  int n_hits;
  int n_cfg;
  int n_checked;

  // Rows with fixed set carry a hand-written answer; the rest use the map model.
  probe_t probes [25] = '{
    '{OP_TEST,  10'd0,    11'd0,    1'b1, 1'b1, 10'd0, 1'b0},
    '{OP_TEST,  10'd1023, 11'd0,    1'b1, 1'b1, 10'd0, 1'b0},
    '{OP_SCAN,  10'd0,    11'd0,    1'b1, 1'b0, 10'd0, 1'b0},
    '{OP_SCAN,  10'd0,    11'd1024, 1'b1, 1'b1, 10'd0, 1'b0},
    '{OP_SCAN,  10'd0,    11'd1025, 1'b1, 1'b0, 10'd0, 1'b0},
    '{OP_SCAN,  10'd1023, 11'd2047, 1'b1, 1'b0, 10'd0, 1'b0},
    '{OP_SET,   10'd0,    11'd0,    1'b1, 1'b1, 10'd0, 1'b0},
    '{OP_SET,   10'd1023, 11'd0,    1'b1, 1'b1, 10'd0, 1'b0},
    '{OP_TEST,  10'd1023, 11'd0,    1'b1, 1'b1, 10'd0, 1'b1},
    '{OP_SCAN,  10'd0,    11'd1,    1'b1, 1'b1, 10'd1, 1'b0},
    '{OP_SCAN,  10'd0,    11'd1022, 1'b1, 1'b1, 10'd1, 1'b0},
    '{OP_SCAN,  10'd0,    11'd1023, 1'b1, 1'b0, 10'd0, 1'b0},
    '{OP_SET,   10'd512,  11'd0,    1'b0, 1'b0, 10'd0, 1'b0},
    '{OP_SCAN,  10'd0,    11'd600,  1'b0, 1'b0, 10'd0, 1'b0},
    '{OP_SCAN,  10'd0,    11'd511,  1'b0, 1'b0, 10'd0, 1'b0},
    '{OP_CLEAR, 10'd0,    11'd0,    1'b1, 1'b1, 10'd0, 1'b0},
    '{OP_TEST,  10'd0,    11'd0,    1'b1, 1'b1, 10'd0, 1'b0},
    '{OP_RSVD_A, 10'd1023, 11'd2047, 1'b1, 1'b0, 10'd0, 1'b0},
    '{OP_RSVD_B, 10'd0,   11'd0,    1'b1, 1'b0, 10'd0, 1'b0},
    '{OP_RSVD_C, 10'd341, 11'd1365, 1'b1, 1'b0, 10'd0, 1'b0},
    '{OP_SET,   10'd682,  11'd0,    1'b0, 1'b0, 10'd0, 1'b0},
    '{OP_TEST,  10'd682,  11'd0,    1'b0, 1'b0, 10'd0, 1'b0},
    '{OP_WIPE,  10'd0,    11'd0,    1'b1, 1'b1, 10'd0, 1'b0},
    '{OP_TEST,  10'd1023, 11'd0,    1'b1, 1'b1, 10'd0, 1'b0},
    '{OP_SCAN,  10'd0,    11'd1024, 1'b1, 1'b1, 10'd0, 1'b0}
  };

  function automatic int live_bits();
    int n;
    n = int'(map_bytes) * 8;
    return (n > MAP_BITS) ? MAP_BITS : n;
  endfunction

  function automatic void first_fit(input int need, output logic hit,
                                    output logic [INDEX_W-1:0] at);
    int run;
    int lim;
    hit = 1'b0;
    at = '0;
    run = 0;
    lim = live_bits();
    if (need == 0) return;
    for (int i = 0; i < lim; i++) begin
      run = usage[i] ? 0 : run + 1;
      if (run == need) begin
        hit = 1'b1;
        at = INDEX_W'(i + 1 - need);
        return;
      end
    end
  endfunction

  function automatic void apply_request(input logic [FUNC_W-1:0] f,
                                        input logic [INDEX_W-1:0] idx,
                                        input logic [LEN_W-1:0] len,
                                        output alloc_result_t r);
    int lim;
    r = '0;
    lim = live_bits();
    case (f)
      OP_SCAN: begin
        first_fit(int'(len), r.found, r.start);
        n_scans++;
        if (r.found) n_hits++;
      end
      OP_SET: begin
        if (int'(idx) < MAP_BITS) begin
          usage[idx] = 1'b1;
          r.found = 1'b1;
        end
      end
      OP_CLEAR: begin
        if (int'(idx) < MAP_BITS) begin
          usage[idx] = 1'b0;
          r.found = 1'b1;
        end
      end
      OP_TEST: begin
        if (int'(idx) < MAP_BITS) begin
          r.bit_value = usage[idx];
          r.found = 1'b1;
        end
      end
      OP_WIPE: begin
        for (int i = 0; i < lim; i++) usage[i] = 1'b0;
        r.found = 1'b1;
      end
      default: begin
      end
    endcase
  endfunction

  function automatic probe_t random_row();
    probe_t p;
    int k;
    int lim;
    p = '0;
    k = $urandom_range(0, 99);
    lim = live_bits();
    if (lim > 0 && $urandom_range(0, 3) != 0) p.idx = INDEX_W'($urandom_range(0, lim - 1));
    else p.idx = INDEX_W'($urandom_range(0, 1023));
    p.len = LEN_W'($urandom_range(0, 2047));
    if (k < 35) begin
      p.func = OP_SCAN;
      case ($urandom_range(0, 9))
        0: p.len = '0;
        1: begin
        end
        2: p.len = LEN_W'(lim + $urandom_range(0, 2));
        3: p.len = LEN_W'($urandom_range(1, (lim > 0) ? lim : 1));
        default: p.len = LEN_W'($urandom_range(1, 12));
      endcase
    end else if (k < 55) begin
      p.func = OP_SET;
    end else if (k < 75) begin
      p.func = OP_CLEAR;
    end else if (k < 92) begin
      p.func = OP_TEST;
    end else if (k < 95) begin
      p.func = OP_WIPE;
    end else begin
      p.func = OP_RSVD_A + FUNC_W'($urandom_range(0, 2));
    end
    return p;
  endfunction

  task automatic issue(input probe_t p, output alloc_result_t pred);
    req.valid <= 1'b1;
    req.func <= p.func;
    req.bit_addr <= p.idx;
    req.run_length <= p.len;
    do @(posedge clk); while (!req.ready);
    apply_request(p.func, p.idx, p.len, pred);
    if (p.fixed) awaited.push_back({p.w_found, p.w_start, p.w_bit});
    else awaited.push_back(pred);
    n_items++;
    calm = (n_items >= ITEMS - CALM_ITEMS);
    if (!calm && $urandom_range(0, 9) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic set_map_bytes(input logic [BYTES_W-1:0] v);
    req.valid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.map_bytes_in_use <= v;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    map_bytes = v;
    n_cfg++;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    int cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Timed out after %0d cycles with %0d results outstanding.",
                 cycles, awaited.size());
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    int hold;
    alloc_result_t want;
    hold = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rsp.valid && rsp.ready) begin
        if (awaited.size() == 0) begin
          $display("%0t: unexpected result beat: found %0d start %0d bit %0d", $time,
                   rsp.found, rsp.start_index, rsp.bit_value);
          errors++;
        end else begin
          want = awaited.pop_front();
          n_checked++;
          if (rsp.found !== want.found) begin
            $display("%0t: found expected %0d, actual %0d", $time, want.found, rsp.found);
            errors++;
          end
          if (rsp.start_index !== want.start) begin
            $display("%0t: start_index expected %0d, actual %0d", $time, want.start,
                     rsp.start_index);
            errors++;
          end
          if (rsp.bit_value !== want.bit_value) begin
            $display("%0t: bit_value expected %0d, actual %0d", $time, want.bit_value,
                     rsp.bit_value);
            errors++;
          end
        end
      end
      if (hold > 0) begin
        hold--;
        rsp.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        hold = $urandom_range(0, 18);
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  initial begin
    alloc_result_t got;
    alloc_result_t dummy;
    probe_t p;
    logic [BYTES_W-1:0] plan [10];
    int phase_end;
    int n;
    errors = 0;
    n_items = 0;
    n_scans = 0;
    n_hits = 0;
    n_cfg = 0;
    n_checked = 0;
    calm = 1'b0;
    map_bytes = BYTES_RESET;
    for (int i = 0; i < MAP_BITS; i++) usage[i] = 1'b0;
    rst <= 1'b1;
    req.valid <= 1'b0;
    req.func <= OP_SCAN;
    req.bit_addr <= '0;
    req.run_length <= '0;
    cfg.valid <= 1'b0;
    cfg.map_bytes_in_use <= BYTES_RESET;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (probes[i]) issue(probes[i], got);

    plan = '{8'd1, 8'd0, 8'd255, 8'd16, 8'd129, 8'd0, 8'd64, 8'd3, 8'd200, 8'd128};
    plan[5] = BYTES_W'($urandom_range(2, 127));
    foreach (plan[ph]) begin
      set_map_bytes(plan[ph]);
      phase_end = 25 + (ph + 1) * (ITEMS - 25) / 10;
      while (n_items < phase_end) begin
        if ($urandom_range(0, 9) < 3) begin
          // Allocation: find a free run, then mark every unit of it used.
          p = '0;
          p.func = OP_SCAN;
          p.idx = INDEX_W'($urandom_range(0, 1023));
          p.len = LEN_W'($urandom_range(1, 8));
          issue(p, got);
          if (got.found) begin
            n = int'(p.len);
            p.func = OP_SET;
            for (int b = 0; b < n; b++) begin
              p.idx = got.start + INDEX_W'(b);
              issue(p, dummy);
            end
          end
        end else begin
          issue(random_row(), got);
        end
      end
    end

    req.valid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Sent %0d requests across %0d map sizes, from empty to oversized.",
             n_items, n_cfg);
    $display("%0d scans of which %0d found a run; %0d results checked.",
             n_scans, n_hits, n_checked);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/bra_pkg.sv
rtl/bra_if.sv
rtl/bra_ctrl.sv
rtl/bra_datapath.sv
rtl/bitmap_run_allocator.sv
rtl/bra_checker.sv
verif/bitmap_run_allocator_test.sv
